// ===== design/wlo_pkg.sv =====
// ----------------------------------------------------------------------------
// wlo_pkg
// Shared constants and register codes for the waypoint lateral offset block.
// ----------------------------------------------------------------------------
package wlo_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int ID_BITS_DEF    = 16;

  localparam int CFG_W   = 16;  // width of every configuration register
  localparam int FRAC_W  = 8;   // fraction bits of the interpolated offset
  localparam int NORM_W  = 30;  // normalized segment component width
  localparam int ROOT_W  = 31;  // segment length width
  localparam int RAD_W   = 62;  // radicand width
  localparam int QI_W    = 24;  // interpolation quotient width
  localparam int QG_W    = 17;  // displacement quotient width
  localparam int M_W     = 26;  // signed Q8 offset width
  localparam int MAG_W   = 25;  // magnitude of the Q8 offset
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_FIRST_START_ID,
    REG_SECOND_START_ID,
    REG_FIRST_END_ID,
    REG_SECOND_END_ID,
    REG_FIRST_START_OFF,
    REG_SECOND_START_OFF,
    REG_FIRST_END_OFF,
    REG_SECOND_END_OFF
  } reg_idx_e;

endpackage

// ===== design/wlo_div_pipe.sv =====
// ----------------------------------------------------------------------------
// wlo_div_pipe
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// valid bit and a sideband vector that travel alongside.
// ----------------------------------------------------------------------------
module wlo_div_pipe #(
  parameter int NUM_W  = 16,
  parameter int DEN_W  = 8,
  parameter int QUO_W  = 8,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int RW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic              v_q    [QUO_W];
  logic [QUO_W-1:0]  quo_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];
  logic [RW-1:0]     rem_q  [QUO_W-1];
  logic [DEN_W-1:0]  den_q  [QUO_W-1];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    localparam int B = QUO_W - 1 - j;
    logic              v_in;
    logic [RW-1:0]     rem_in;
    logic [RW-1:0]     dsh;
    logic [QUO_W-1:0]  quo_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic              ge;

    if (j == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = RW'(num_i);
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign den_in  = den_q[j-1];
      assign side_in = side_q[j-1];
    end

    assign dsh = RW'(den_in) << B;
    assign ge  = (rem_in >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j]  <= ge ? (quo_in | (QUO_W'(1) << B)) : quo_in;
        side_q[j] <= side_in;
      end
    end

    if (j < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= ge ? (rem_in - dsh) : rem_in;
          den_q[j] <= den_in;
        end
      end
    end
  end

  assign valid_o = v_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

// ===== design/waypoint_lateral_offset.sv =====
// ----------------------------------------------------------------------------
// waypoint_lateral_offset
// Shifts the previous waypoint along the unit normal of its segment by an
// offset interpolated over three id ranges.
// ----------------------------------------------------------------------------
// From accepted transaction to out_valid_o the pipe passes the 24-stage
// interpolation divider, the 31-stage square root and the 17-stage
// displacement dividers.
// Throughput: one transaction per cycle; an output stall freezes the pipe.
// Reset clears all valid bits and the configuration registers to zero.
module waypoint_lateral_offset #(
  parameter int COORD_BITS = wlo_pkg::COORD_BITS_DEF,
  parameter int ID_BITS    = wlo_pkg::ID_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wlo_pkg::PADDR_W-1:0]   paddr,
  input  logic [wlo_pkg::PDATA_W-1:0]   pwdata,
  output logic [wlo_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ID_BITS-1:0]            point_id_i,
  input  logic signed [COORD_BITS-1:0]  prev_x_i,
  input  logic signed [COORD_BITS-1:0]  prev_y_i,
  input  logic signed [COORD_BITS-1:0]  cur_x_i,
  input  logic signed [COORD_BITS-1:0]  cur_y_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wlo_pkg::CFG_W-1:0]     out_id_o,
  output logic signed [COORD_BITS-1:0]  shifted_x_o,
  output logic signed [COORD_BITS-1:0]  shifted_y_o,
  output logic signed [wlo_pkg::CFG_W-1:0] offset_used_o,
  output logic                          degenerate_o
);

  localparam int CW    = COORD_BITS;
  localparam int DXW   = CW + 1;
  localparam int NW    = (DXW > wlo_pkg::NORM_W) ? DXW : wlo_pkg::NORM_W;
  localparam int NS    = $clog2(NW);
  localparam int EW    = (ID_BITS > wlo_pkg::CFG_W) ? ID_BITS : wlo_pkg::CFG_W;
  localparam int RW16  = wlo_pkg::CFG_W;
  localparam int PW    = 2 * (RW16 + 1);
  localparam int N1W   = PW + wlo_pkg::FRAC_W;
  localparam int NRM   = wlo_pkg::NORM_W;
  localparam int RTW   = wlo_pkg::ROOT_W;
  localparam int RADW  = wlo_pkg::RAD_W;
  localparam int MW    = wlo_pkg::M_W;
  localparam int MAGW  = wlo_pkg::MAG_W;
  localparam int GPW   = MAGW + NRM;
  localparam int N2W   = GPW + 1;
  localparam int D2W   = RTW + wlo_pkg::FRAC_W;
  localparam int QGW   = wlo_pkg::QG_W;
  localparam int QIW   = wlo_pkg::QI_W;
  localparam int SUMW  = ((CW > QGW + 1) ? CW : QGW + 1) + 1;

  localparam int NSW = RW16 + 2*CW + 3 + RW16 + RW16 + PW;
  localparam int S3W = RW16 + 2*CW + 3 + RW16 + 2 + 2*NRM;
  localparam int S4W = RW16 + 2*CW + 3 + 2*NRM;
  localparam int S5W = S4W + RW16 + MAGW + 1;
  localparam int S6W = RW16 + 2*CW + 1 + RW16 + 2;
  localparam int SXW = RW16 + CW + 1 + RW16 + 1;
  localparam int SYW = CW + 1;

  logic out_valid_q;
  logic en;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [RW16-1:0]   id_q  [4];
  logic [RW16-1:0]   off_q [4];
  wlo_pkg::reg_idx_e cfg_idx;

  assign cfg_idx = wlo_pkg::reg_idx_e'(paddr[wlo_pkg::PADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        id_q[i]  <= '0;
        off_q[i] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      unique case (cfg_idx)
        wlo_pkg::REG_FIRST_START_ID:   id_q[0]  <= pwdata[RW16-1:0];
        wlo_pkg::REG_SECOND_START_ID:  id_q[1]  <= pwdata[RW16-1:0];
        wlo_pkg::REG_FIRST_END_ID:     id_q[2]  <= pwdata[RW16-1:0];
        wlo_pkg::REG_SECOND_END_ID:    id_q[3]  <= pwdata[RW16-1:0];
        wlo_pkg::REG_FIRST_START_OFF:  off_q[0] <= pwdata[RW16-1:0];
        wlo_pkg::REG_SECOND_START_OFF: off_q[1] <= pwdata[RW16-1:0];
        wlo_pkg::REG_FIRST_END_OFF:    off_q[2] <= pwdata[RW16-1:0];
        wlo_pkg::REG_SECOND_END_OFF:   off_q[3] <= pwdata[RW16-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      wlo_pkg::REG_FIRST_START_ID:   prdata = wlo_pkg::PDATA_W'(id_q[0]);
      wlo_pkg::REG_SECOND_START_ID:  prdata = wlo_pkg::PDATA_W'(id_q[1]);
      wlo_pkg::REG_FIRST_END_ID:     prdata = wlo_pkg::PDATA_W'(id_q[2]);
      wlo_pkg::REG_SECOND_END_ID:    prdata = wlo_pkg::PDATA_W'(id_q[3]);
      wlo_pkg::REG_FIRST_START_OFF:  prdata = wlo_pkg::PDATA_W'($signed(off_q[0]));
      wlo_pkg::REG_SECOND_START_OFF: prdata = wlo_pkg::PDATA_W'($signed(off_q[1]));
      wlo_pkg::REG_FIRST_END_OFF:    prdata = wlo_pkg::PDATA_W'($signed(off_q[2]));
      wlo_pkg::REG_SECOND_END_OFF:   prdata = wlo_pkg::PDATA_W'($signed(off_q[3]));
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage 1: range select, segment delta
  // --------------------------------------------------------------------------
  logic [EW-1:0]   id_x;
  logic [EW-1:0]   bnd [4];
  logic            hit_c;
  logic [RW16-1:0] lo_id, hi_id, lo_off, hi_off;
  logic signed [DXW-1:0] dx_c, dy_c;
  logic signed [RW16:0]  diff_c;

  assign id_x = EW'(point_id_i);
  for (genvar k = 0; k < 4; k++) begin : g_bnd
    assign bnd[k] = EW'(id_q[k]);
  end

  // earlier range wins where registers overlap
  always_comb begin
    hit_c  = 1'b1;
    lo_id  = id_q[2];
    hi_id  = id_q[3];
    lo_off = off_q[2];
    hi_off = off_q[3];
    priority if (id_x >= bnd[0] && id_x < bnd[1]) begin
      lo_id  = id_q[0];
      hi_id  = id_q[1];
      lo_off = off_q[0];
      hi_off = off_q[1];
    end else if (id_x >= bnd[1] && id_x < bnd[2]) begin
      lo_id  = id_q[1];
      hi_id  = id_q[2];
      lo_off = off_q[1];
      hi_off = off_q[2];
    end else if (id_x >= bnd[2] && id_x <= bnd[3]) begin
      hit_c  = 1'b1;
    end else begin
      hit_c  = 1'b0;
    end
  end

  assign dx_c   = $signed({cur_x_i[CW-1], cur_x_i}) - $signed({prev_x_i[CW-1], prev_x_i});
  assign dy_c   = $signed({cur_y_i[CW-1], cur_y_i}) - $signed({prev_y_i[CW-1], prev_y_i});
  assign diff_c = $signed({hi_off[RW16-1], hi_off}) - $signed({lo_off[RW16-1], lo_off});

  logic                  v1_q;
  logic [RW16-1:0]       id1_q, cnt1_q, span1_q, lo1_q;
  logic [CW-1:0]         px1_q, py1_q;
  logic signed [DXW-1:0] dx1_q, dy1_q;
  logic signed [RW16:0]  diff1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i && hit_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      id1_q   <= id_x[RW16-1:0];
      cnt1_q  <= id_x[RW16-1:0] - lo_id;
      span1_q <= hi_id - lo_id;
      lo1_q   <= lo_off;
      px1_q   <= prev_x_i;
      py1_q   <= prev_y_i;
      dx1_q   <= dx_c;
      dy1_q   <= dy_c;
      diff1_q <= diff_c;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: interpolation product, absolute deltas
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] prod_c;
  logic [DXW-1:0]       ax_c, ay_c;
  logic                 dg_c;

  assign prod_c = diff1_q * $signed({1'b0, cnt1_q});
  assign ax_c   = dx1_q[DXW-1] ? DXW'(-dx1_q) : DXW'(dx1_q);
  assign ay_c   = dy1_q[DXW-1] ? DXW'(-dy1_q) : DXW'(dy1_q);
  assign dg_c   = (dx1_q == '0) && (dy1_q == '0);

  logic           v2_q;
  logic [NW-1:0]  ax2_q, ay2_q;
  logic [NSW-1:0] sd2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax2_q <= NW'(ax_c);
      ay2_q <= NW'(ay_c);
      sd2_q <= {id1_q, px1_q, py1_q, dx1_q[DXW-1], dy1_q[DXW-1], dg_c,
                lo1_q, span1_q, prod_c};
    end
  end

  // --------------------------------------------------------------------------
  // Normalize: shift both components left until the larger one has its
  // leading one at the top bit; the top NORM_W bits then match the rescaling.
  // --------------------------------------------------------------------------
  logic           nv_q  [NS];
  logic [NW-1:0]  nax_q [NS];
  logic [NW-1:0]  nay_q [NS];
  logic [NSW-1:0] nsd_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_norm
    localparam int SH = 2 ** (NS - 1 - k);
    logic           v_in;
    logic [NW-1:0]  a_in, b_in, or_v;
    logic [NSW-1:0] s_in;

    if (k == 0) begin : g_first
      assign v_in = v2_q;
      assign a_in = ax2_q;
      assign b_in = ay2_q;
      assign s_in = sd2_q;
    end else begin : g_next
      assign v_in = nv_q[k-1];
      assign a_in = nax_q[k-1];
      assign b_in = nay_q[k-1];
      assign s_in = nsd_q[k-1];
    end

    assign or_v = a_in | b_in;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nv_q[k] <= 1'b0;
      end else if (en) begin
        nv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (or_v[NW-1 -: SH] == '0) begin
          nax_q[k] <= a_in << SH;
          nay_q[k] <= b_in << SH;
        end else begin
          nax_q[k] <= a_in;
          nay_q[k] <= b_in;
        end
        nsd_q[k] <= s_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: rounded numerator for the interpolation divider
  // --------------------------------------------------------------------------
  logic [RW16-1:0]      n_id, n_lo, n_span;
  logic [CW-1:0]        n_px, n_py;
  logic                 n_sgx, n_sgy, n_dg;
  logic signed [PW-1:0] n_prod;
  logic [PW-1:0]        pmag_c;
  logic [N1W-1:0]       num1_c;

  assign {n_id, n_px, n_py, n_sgx, n_sgy, n_dg, n_lo, n_span, n_prod} = nsd_q[NS-1];
  assign pmag_c = n_prod[PW-1] ? PW'(-n_prod) : PW'(n_prod);
  assign num1_c = (N1W'(pmag_c) << wlo_pkg::FRAC_W) + N1W'(n_span >> 1);

  logic            v3_q;
  logic [N1W-1:0]  num3_q;
  logic [RW16-1:0] den3_q;
  logic [S3W-1:0]  sd3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= nv_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num3_q <= num1_c;
      den3_q <= n_span;
      sd3_q  <= {n_id, n_px, n_py, n_sgx, n_sgy, n_dg, n_lo, (n_span == '0),
                 n_prod[PW-1], nax_q[NS-1][NW-1 -: NRM], nay_q[NS-1][NW-1 -: NRM]};
    end
  end

  logic           d1_v;
  logic [QIW-1:0] d1_q;
  logic [S3W-1:0] d1_side;

  wlo_div_pipe #(
    .NUM_W  (N1W),
    .DEN_W  (RW16),
    .QUO_W  (QIW),
    .SIDE_W (S3W)
  ) u_div_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   (num3_q),
    .den_i   (den3_q),
    .side_i  (sd3_q),
    .valid_o (d1_v),
    .quo_o   (d1_q),
    .side_o  (d1_side)
  );

  // --------------------------------------------------------------------------
  // Stage M: Q8 offset, squared components
  // --------------------------------------------------------------------------
  logic [RW16-1:0]        m_id;
  logic signed [RW16-1:0] m_lo;
  logic [CW-1:0]          m_px, m_py;
  logic                   m_sgx, m_sgy, m_dg, m_zspan, m_nsign;
  logic [NRM-1:0]         m_nax, m_nay;
  logic signed [MW-1:0]   qsg_c, m_c;
  logic [2*NRM-1:0]       sqx_c, sqy_c;

  assign {m_id, m_px, m_py, m_sgx, m_sgy, m_dg, m_lo, m_zspan, m_nsign,
          m_nax, m_nay} = d1_side;

  // an empty span (range three with equal ends) keeps the start offset
  assign qsg_c = m_zspan ? '0 : (m_nsign ? -$signed(MW'(d1_q)) : $signed(MW'(d1_q)));
  assign m_c   = (MW'(m_lo) <<< wlo_pkg::FRAC_W) + qsg_c;
  assign sqx_c = m_nax * m_nax;
  assign sqy_c = m_nay * m_nay;

  logic                 v4_q;
  logic signed [MW-1:0] m4_q;
  logic [2*NRM-1:0]     sqx4_q, sqy4_q;
  logic [S4W-1:0]       sd4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= d1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m4_q   <= m_c;
      sqx4_q <= sqx_c;
      sqy4_q <= sqy_c;
      sd4_q  <= {m_id, m_px, m_py, m_sgx, m_sgy, m_dg, m_nax, m_nay};
    end
  end

  // --------------------------------------------------------------------------
  // Stage Q: radicand, offset magnitude and rounded offset
  // --------------------------------------------------------------------------
  logic [MAGW-1:0] mmag_c, rnd_c;
  logic [RW16-1:0] offu_c;

  assign mmag_c = m4_q[MW-1] ? MAGW'(-m4_q) : MAGW'(m4_q);
  assign rnd_c  = (mmag_c + MAGW'(2 ** (wlo_pkg::FRAC_W - 1))) >> wlo_pkg::FRAC_W;
  assign offu_c = m4_q[MW-1] ? RW16'(-rnd_c) : RW16'(rnd_c);

  logic            v5_q;
  logic [RADW-1:0] rad5_q;
  logic [S5W-1:0]  sd5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad5_q <= RADW'(sqx4_q) + RADW'(sqy4_q);
      sd5_q  <= {sd4_q, offu_c, mmag_c, m4_q[MW-1]};
    end
  end

  // --------------------------------------------------------------------------
  // Square root, one root bit per stage
  // --------------------------------------------------------------------------
  logic            sv_q   [RTW];
  logic [RTW-1:0]  root_q [RTW];
  logic [S5W-1:0]  ssd_q  [RTW];
  logic [RADW-1:0] srem_q [RTW-1];

  for (genvar j = 0; j < RTW; j++) begin : g_sqrt
    localparam int B = RTW - 1 - j;
    logic            v_in, ge;
    logic [RADW-1:0] rem_in, trial;
    logic [RTW-1:0]  root_in;
    logic [S5W-1:0]  s_in;

    if (j == 0) begin : g_first
      assign v_in    = v5_q;
      assign rem_in  = rad5_q;
      assign root_in = '0;
      assign s_in    = sd5_q;
    end else begin : g_next
      assign v_in    = sv_q[j-1];
      assign rem_in  = srem_q[j-1];
      assign root_in = root_q[j-1];
      assign s_in    = ssd_q[j-1];
    end

    // (root + 2^B)^2 - root^2, root holding only bits above B
    assign trial = (RADW'(root_in) << (B + 1)) | (RADW'(1) << (2 * B));
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j] <= 1'b0;
      end else if (en) begin
        sv_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        root_q[j] <= ge ? (root_in | (RTW'(1) << B)) : root_in;
        ssd_q[j]  <= s_in;
      end
    end

    if (j < RTW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en) begin
          srem_q[j] <= ge ? (rem_in - trial) : rem_in;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage P: offset times normalized components
  // --------------------------------------------------------------------------
  logic [RW16-1:0] p_id, p_offu;
  logic [CW-1:0]   p_px, p_py;
  logic            p_sgx, p_sgy, p_dg, p_sm;
  logic [NRM-1:0]  p_nax, p_nay;
  logic [MAGW-1:0] p_mmag;

  assign {p_id, p_px, p_py, p_sgx, p_sgy, p_dg, p_nax, p_nay, p_offu, p_mmag,
          p_sm} = ssd_q[RTW-1];

  logic           v6_q;
  logic [GPW-1:0] gx6_q, gy6_q;
  logic [RTW-1:0] root6_q;
  logic [S6W-1:0] sd6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= sv_q[RTW-1];
    end
  end

  // x moves along dy, y along -dx
  always_ff @(posedge clk_i) begin
    if (en) begin
      gx6_q   <= p_mmag * p_nay;
      gy6_q   <= p_mmag * p_nax;
      root6_q <= root_q[RTW-1];
      sd6_q   <= {p_id, p_px, p_py, p_dg, p_offu, p_sm ^ p_sgy, !(p_sm ^ p_sgx)};
    end
  end

  // --------------------------------------------------------------------------
  // Stage N: rounded numerators, scaled length
  // --------------------------------------------------------------------------
  logic [RW16-1:0] q_id, q_offu;
  logic [CW-1:0]   q_px, q_py;
  logic            q_dg, q_xneg, q_yneg;

  assign {q_id, q_px, q_py, q_dg, q_offu, q_xneg, q_yneg} = sd6_q;

  logic           v7_q;
  logic [N2W-1:0] nx7_q, ny7_q;
  logic [D2W-1:0] den7_q;
  logic [SXW-1:0] sx7_q;
  logic [SYW-1:0] sy7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (en) begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx7_q  <= N2W'(gx6_q) + (N2W'(root6_q) << (wlo_pkg::FRAC_W - 1));
      ny7_q  <= N2W'(gy6_q) + (N2W'(root6_q) << (wlo_pkg::FRAC_W - 1));
      den7_q <= D2W'(root6_q) << wlo_pkg::FRAC_W;
      sx7_q  <= {q_id, q_px, q_dg, q_offu, q_xneg};
      sy7_q  <= {q_py, q_yneg};
    end
  end

  logic           dx_v, dy_v;
  logic [QGW-1:0] dx_q, dy_q;
  logic [SXW-1:0] dx_side;
  logic [SYW-1:0] dy_side;

  wlo_div_pipe #(
    .NUM_W  (N2W),
    .DEN_W  (D2W),
    .QUO_W  (QGW),
    .SIDE_W (SXW)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_i   (nx7_q),
    .den_i   (den7_q),
    .side_i  (sx7_q),
    .valid_o (dx_v),
    .quo_o   (dx_q),
    .side_o  (dx_side)
  );

  wlo_div_pipe #(
    .NUM_W  (N2W),
    .DEN_W  (D2W),
    .QUO_W  (QGW),
    .SIDE_W (SYW)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_i   (ny7_q),
    .den_i   (den7_q),
    .side_i  (sy7_q),
    .valid_o (dy_v),
    .quo_o   (dy_q),
    .side_o  (dy_side)
  );

  // --------------------------------------------------------------------------
  // Final: add to previous point, saturate, output register
  // --------------------------------------------------------------------------
  logic [RW16-1:0]        f_id, f_offu;
  logic signed [CW-1:0]   f_px, f_py;
  logic                   f_dg, f_xneg, f_yneg;
  logic signed [SUMW-1:0] qx_s, qy_s, sumx_c, sumy_c;
  logic signed [CW-1:0]   satx_c, saty_c;
  logic [SUMW-CW:0]       topx, topy;

  assign {f_id, f_px, f_dg, f_offu, f_xneg} = dx_side;
  assign {f_py, f_yneg} = dy_side;

  assign qx_s   = f_xneg ? -$signed(SUMW'(dx_q)) : $signed(SUMW'(dx_q));
  assign qy_s   = f_yneg ? -$signed(SUMW'(dy_q)) : $signed(SUMW'(dy_q));
  assign sumx_c = SUMW'(f_px) + qx_s;
  assign sumy_c = SUMW'(f_py) + qy_s;
  assign topx   = sumx_c[SUMW-1:CW-1];
  assign topy   = sumy_c[SUMW-1:CW-1];

  always_comb begin
    if ((&topx) || !(|topx)) begin
      satx_c = sumx_c[CW-1:0];
    end else begin
      satx_c = sumx_c[SUMW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    if ((&topy) || !(|topy)) begin
      saty_c = sumy_c[CW-1:0];
    end else begin
      saty_c = sumy_c[SUMW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
  end

  logic [RW16-1:0]        out_id_q, out_off_q;
  logic signed [CW-1:0]   out_x_q, out_y_q;
  logic                   out_dg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dx_v && dy_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_id_q  <= f_id;
      out_off_q <= f_offu;
      out_x_q   <= f_dg ? f_px : satx_c;
      out_y_q   <= f_dg ? f_py : saty_c;
      out_dg_q  <= f_dg;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_id_o      = out_id_q;
  assign shifted_x_o   = out_x_q;
  assign shifted_y_o   = out_y_q;
  assign offset_used_o = out_off_q;
  assign degenerate_o  = out_dg_q;

endmodule

// ===== dv/tb_waypoint_lateral_offset.sv =====
// ----------------------------------------------------------------------------
// tb_waypoint_lateral_offset
// Self-checking bench: random and directed waypoints under several range and
// offset settings, results compared against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_waypoint_lateral_offset;

  localparam int CB = 32;
  localparam int LAT = 86;
  localparam int LIMIT = 2000000;
  localparam int AW = wlo_pkg::PADDR_W;
  localparam int DW = wlo_pkg::PDATA_W;

  typedef struct {
    logic [15:0] id;
    logic signed [CB-1:0] px, py, cx, cy;
  } waypoint_t;

  typedef struct {
    logic [15:0] id;
    logic signed [CB-1:0] sx, sy;
    logic signed [15:0] off;
    logic degen;
  } shifted_t;

  logic clk_i = 0, rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [AW-1:0] paddr = '0;
  logic [DW-1:0] pwdata = '0;
  logic [DW-1:0] prdata;
  logic pready;
  logic in_valid_i = 0, in_stall_o;
  logic [15:0] point_id_i = '0;
  logic signed [CB-1:0] prev_x_i = '0, prev_y_i = '0, cur_x_i = '0, cur_y_i = '0;
  logic out_valid_o, out_stall_i = 0, degenerate_o;
  logic [15:0] out_id_o;
  logic signed [CB-1:0] shifted_x_o, shifted_y_o;
  logic signed [15:0] offset_used_o;

  waypoint_lateral_offset u_top (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  waypoint_t pending_pts[$];
  shifted_t expected_pts[$];
  logic [15:0] range_id[4];
  longint range_off[4];
  int errors = 0;
  int cycles = 0;
  bit idle_en = 0;
  int hold_off = 0;

  function automatic longint round_div(longint n, longint d);
    longint q;
    q = ((n < 0 ? -n : n) + d / 2) / d;
    return n < 0 ? -q : q;
  endfunction

  function automatic longint root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint ramp_mag(longint id, int r);
    longint span, cnt;
    span = longint'(range_id[r+1]) - longint'(range_id[r]);
    cnt = id - longint'(range_id[r]);
    if (span <= 0) return range_off[r] * 256;
    return range_off[r] * 256 +
           round_div((range_off[r+1] - range_off[r]) * cnt * 256, span);
  endfunction

  function automatic longint clamp_coord(longint v);
    longint hi;
    hi = (longint'(1) <<< (CB - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  // returns 0 when the id falls in no range
  function automatic bit predict_shift(waypoint_t w, output shifted_t s);
    longint id, m, dx, dy, nx, ny, den;
    longint unsigned ax, ay, mx;
    id = w.id;
    if (id >= range_id[0] && id < range_id[1]) m = ramp_mag(id, 0);
    else if (id >= range_id[1] && id < range_id[2]) m = ramp_mag(id, 1);
    else if (id >= range_id[2] && id <= range_id[3]) m = ramp_mag(id, 2);
    else return 0;
    dx = longint'(w.cx) - longint'(w.px);
    dy = longint'(w.cy) - longint'(w.py);
    s.id = w.id;
    s.off = 16'(round_div(m, 256));
    s.sx = w.px;
    s.sy = w.py;
    s.degen = (dx == 0 && dy == 0);
    if (!s.degen) begin
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      mx = ax > ay ? ax : ay;
      while (mx >= (64'd1 << 30)) begin ax >>= 1; ay >>= 1; mx >>= 1; end
      while (mx < (64'd1 << 29)) begin ax <<= 1; ay <<= 1; mx <<= 1; end
      nx = dx < 0 ? -longint'(ax) : longint'(ax);
      ny = dy < 0 ? -longint'(ay) : longint'(ay);
      den = 256 * root64(ax * ax + ay * ay);
      s.sx = CB'(clamp_coord(longint'(w.px) + round_div(m * ny, den)));
      s.sy = CB'(clamp_coord(longint'(w.py) + round_div(-m * nx, den)));
    end
    return 1;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // driver
  always @(posedge clk_i) begin
    shifted_t s;
    waypoint_t w;
    bit acc;
    if (rst_ni) begin
      acc = in_valid_i && !in_stall_o;
      if (acc) begin
        if (predict_shift(pending_pts[0], s)) expected_pts = {expected_pts, s};
        void'(pending_pts.pop_front());
      end
      if (!in_valid_i || acc) begin
        if (pending_pts.size() > 0 && (!idle_en || $urandom_range(99) >= 33)) begin
          w = pending_pts[0];
          in_valid_i <= 1;
          point_id_i <= w.id;
          prev_x_i <= w.px;
          prev_y_i <= w.py;
          cur_x_i <= w.cx;
          cur_y_i <= w.cy;
        end else begin
          in_valid_i <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    shifted_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_pts.size() == 0) begin
          $error("unexpected transaction id %0d", out_id_o);
          errors++;
        end else begin
          e = expected_pts.pop_front();
          if (out_id_o !== e.id) begin
            $error("out_id exp %0d got %0d", e.id, out_id_o); errors++;
          end
          if (shifted_x_o !== e.sx) begin
            $error("shifted_x exp %0d got %0d", e.sx, shifted_x_o); errors++;
          end
          if (shifted_y_o !== e.sy) begin
            $error("shifted_y exp %0d got %0d", e.sy, shifted_y_o); errors++;
          end
          if (offset_used_o !== e.off) begin
            $error("offset_used exp %0d got %0d", e.off, offset_used_o); errors++;
          end
          if (degenerate_o !== e.degen) begin
            $error("degenerate exp %0d got %0d", e.degen, degenerate_o); errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall_i <= 1;
      end else begin
        out_stall_i <= idle_en && ($urandom_range(99) < 33);
      end
    end
  end

  task automatic reg_write(wlo_pkg::reg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= AW'(4 * int'(idx)); pwdata <= {16'd0, val};
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx < wlo_pkg::REG_FIRST_START_OFF) range_id[idx] = val;
    else range_off[idx - 4] = longint'($signed(val));
  endtask

  task automatic wait_drained();
    while (pending_pts.size() > 0 || expected_pts.size() > 0) @(posedge clk_i);
    repeat (LAT + 10) @(posedge clk_i);
  endtask

  task automatic set_ranges(logic [15:0] a, b, c, d, logic [15:0] o0, o1, o2, o3);
    wait_drained();
    reg_write(wlo_pkg::REG_FIRST_START_ID, a);
    reg_write(wlo_pkg::REG_SECOND_START_ID, b);
    reg_write(wlo_pkg::REG_FIRST_END_ID, c);
    reg_write(wlo_pkg::REG_SECOND_END_ID, d);
    reg_write(wlo_pkg::REG_FIRST_START_OFF, o0);
    reg_write(wlo_pkg::REG_SECOND_START_OFF, o1);
    reg_write(wlo_pkg::REG_FIRST_END_OFF, o2);
    reg_write(wlo_pkg::REG_SECOND_END_OFF, o3);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(2000) - 1000;
      2: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(50) : 32'h80000000 + $urandom_range(50);
      default: return $urandom_range(200000) - 100000;
    endcase
  endfunction

  task automatic add_point(logic [15:0] id, logic [31:0] px, py, cx, cy);
    waypoint_t w;
    w.id = id; w.px = px; w.py = py; w.cx = cx; w.cy = cy;
    pending_pts = {pending_pts, w};
  endtask

  task automatic add_random(int n, int lo, int hi);
    logic [31:0] px, py;
    repeat (n) begin
      px = rand_coord();
      py = rand_coord();
      if ($urandom_range(15) == 0) add_point(16'($urandom_range(hi, lo)), px, py, px, py);
      else if ($urandom_range(1)) add_point(16'($urandom_range(hi, lo)), px, py,
                                            px + rand_coord(), py + rand_coord());
      else add_point(16'($urandom_range(hi, lo)), px, py, rand_coord(), rand_coord());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    for (int i = 0; i < 4; i++) begin range_id[i] = 0; range_off[i] = 0; end
    set_ranges(10, 100, 200, 300, 16'h8000, 16'h7fff, 16'hfc18, 500);
    // directed: range edges, outside ids, degenerate, extreme coordinates
    add_point(9, 0, 0, 1, 0);
    add_point(10, 0, 0, 1, 0);
    add_point(99, 5, 5, 5, 5);
    add_point(100, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
    add_point(199, 32'h80000000, 0, 32'h7fffffff, 0);
    add_point(200, 0, 32'h80000000, 0, 32'h7fffffff);
    add_point(300, 32'h7fffff00, 32'h80000100, 32'h7fffff00, 32'h80000000);
    add_point(301, 0, 0, 3, 4);
    add_point(16'hffff, 1, 2, 3, 4);
    add_point(150, 1000, -1000, 1000, -1000);
    add_point(50, -7, 3, 9, -12);
    add_point(0, 0, 0, 1, 1);
    wait_drained();
    idle_en = 1;
    add_random(300, 0, 400);
    // long output hold-off so the pipe fills and stalls its input
    hold_off = 400;
    add_random(200, 0, 400);
    wait_drained();
    idle_en = 0;
    add_random(150, 0, 400);
    // overlapping ranges, equal range-three ends
    set_ranges(50, 40, 300, 300, 16'h7fff, 16'h8000, 16'h1234, 16'h8000);
    idle_en = 1;
    add_random(250, 0, 400);
    // extremes: full id span
    set_ranges(0, 16'h5555, 16'haaaa, 16'hffff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    add_random(250, 0, 65535);
    set_ranges(16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, 0, 16'h7fff, 0);
    add_random(30, 65500, 65535);
    set_ranges(0, 0, 0, 0, 16'h8000, 0, 16'h8000, 16'h7fff);
    add_random(30, 0, 3);
    set_ranges(1000, 1003, 2000, 9000, -3, 16'h0100, 7, -9);
    add_random(450, 900, 9100);
    wait_drained();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== waypoint_lateral_offset.f =====
design/wlo_pkg.sv
design/wlo_div_pipe.sv
design/waypoint_lateral_offset.sv
dv/tb_waypoint_lateral_offset.sv
